[rtl/core/arp_pkg.sv]
// Package for the AArch64 relocation patch unit: payload types, kind codes, field masks.
`default_nettype none

package arp_pkg;

    // Relocation kinds
    localparam logic [4:0] FN_ABS64     = 5'd0;
    localparam logic [4:0] FN_ABS32     = 5'd1;
    localparam logic [4:0] FN_PREL32    = 5'd2;
    localparam logic [4:0] FN_MOVW_G0   = 5'd3;
    localparam logic [4:0] FN_MOVW_G1   = 5'd4;
    localparam logic [4:0] FN_MOVW_G2   = 5'd5;
    localparam logic [4:0] FN_MOVW_G3   = 5'd6;
    localparam logic [4:0] FN_ADRP      = 5'd7;
    localparam logic [4:0] FN_LO12_S1   = 5'd8;
    localparam logic [4:0] FN_LO12_S16  = 5'd12;
    localparam logic [4:0] FN_CONDBR19  = 5'd13;
    localparam logic [4:0] FN_TSTBR14   = 5'd14;
    localparam logic [4:0] FN_JUMP26    = 5'd15;
    localparam logic [4:0] FN_CALL26    = 5'd16;
    localparam logic [4:0] FN_GOT_PAGE  = 5'd17;
    localparam logic [4:0] FN_GOT_LO12  = 5'd18;
    localparam logic [4:0] FN_COPY      = 5'd19;
    localparam logic [4:0] FN_GLOB_DAT  = 5'd20;
    localparam logic [4:0] FN_TLS_HI12  = 5'd21;
    localparam logic [4:0] FN_TLS_LO12  = 5'd22;
    localparam logic [4:0] FN_RELATIVE  = 5'd23;

    // Write widths
    localparam logic [1:0] WW_NONE = 2'd0;
    localparam logic [1:0] WW_32   = 2'd1;
    localparam logic [1:0] WW_64   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNHANDLED = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TLS_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TCB_BIAS = 8'd1;
    localparam logic [11:0] TCB_BIAS_RESET = 12'd16;

    // Bits of the instruction word kept by each field insert
    localparam logic [31:0] MOVW_KEEP  = 32'hffe0001f;
    localparam logic [31:0] ADRP_KEEP  = 32'h9f00001f;
    localparam logic [31:0] LO12_KEEP  = 32'hffc003ff;
    localparam logic [31:0] COND_KEEP  = 32'hff00001f;
    localparam logic [31:0] TST_KEEP   = 32'hfff8001f;
    localparam logic [31:0] GOTLO_KEEP = 32'hfff803ff;
    localparam logic [31:0] B_OPCODE   = 32'h14000000;
    localparam logic [31:0] BL_BIT     = 32'h80000000;

    typedef struct packed {
        logic [4:0]  func;
        logic [63:0] old_content;
        logic [63:0] place_addr;
        logic [63:0] sym_value;
        logic [63:0] addend;
        logic [63:0] got_entry_addr;
    } t_reloc_in;

    typedef struct packed {
        logic [63:0] new_content;
        logic [1:0]  write_width;
        logic [1:0]  status;
    } t_reloc_out;

endpackage

`default_nettype wire

[rtl/core/aarch64_reloc_patch.sv]
// Top level of the AArch64 relocation patch unit: three-stage pipeline.
`default_nettype none

// One relocation enters per clock whenever i_start is high; o_busy is never
// asserted. Each transfer's result appears on o_result with o_done high for a
// single cycle, in order, once it has passed the stage 1, 2 and 3 registers. Stage 1
// forms the wide differences (S-P, page delta, S-A or old+S, TLS offset),
// stage 2 does the range checks and the narrow adds, stage 3 assembles the
// patched word into the output register. Configuration writes are always
// ready and must only be issued while no item is in flight.
module aarch64_reloc_patch (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    output logic                          o_busy,
    input  arp_pkg::t_reloc_in            i_item,
    output logic                          o_done,
    output arp_pkg::t_reloc_out           o_result,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [arp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [63:0]                    i_cfg_data
);

    // configuration
    logic [63:0] r_tls_base;
    logic [11:0] r_tcb_bias;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tls_base <= '0;
            r_tcb_bias <= arp_pkg::TCB_BIAS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == arp_pkg::CFG_TLS_BASE) begin
                r_tls_base <= i_cfg_data;
            end else if (i_cfg_index == arp_pkg::CFG_TCB_BIAS) begin
                r_tcb_bias <= i_cfg_data[11:0];
            end
        end
    end

    // ---------------- stage 1: wide differences ----------------
    logic        r1_v;
    logic [4:0]  r1_func;
    logic [31:0] r1_insn;
    logic [63:0] r1_s;
    logic [63:0] r1_d;
    logic [63:0] r1_poff;
    logic [63:0] r1_res64;
    logic [23:0] r1_tp;
    logic [8:0]  r1_got_lo;

    logic [63:0] n1_target;
    logic [63:0] n1_sum;
    logic [63:0] n1_diff;

    always_comb begin
        n1_target = (i_item.func == arp_pkg::FN_GOT_PAGE) ? i_item.got_entry_addr
                                                           : i_item.sym_value;
        n1_sum    = i_item.old_content + i_item.sym_value;
        n1_diff   = i_item.sym_value - i_item.addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_func   <= i_item.func;
        r1_insn   <= i_item.old_content[31:0];
        r1_s      <= i_item.sym_value;
        r1_d      <= i_item.sym_value - i_item.place_addr;
        r1_poff   <= {12'd0, n1_target[63:12]} - {12'd0, i_item.place_addr[63:12]};
        r1_res64  <= (i_item.func == arp_pkg::FN_ABS64) ? n1_sum : n1_diff;
        r1_tp     <= i_item.sym_value[23:0] - r_tls_base[23:0];
        r1_got_lo <= i_item.got_entry_addr[11:3];
    end

    // ---------------- stage 2: range checks, narrow adds ----------------
    logic        r2_v;
    logic [4:0]  r2_func;
    logic [31:0] r2_insn;
    logic [63:0] r2_res64;
    logic [31:0] r2_add32;
    logic [15:0] r2_imm16;
    logic [11:0] r2_lo12;
    logic [20:0] r2_page;
    logic [25:0] r2_dbr;
    logic [8:0]  r2_got_lo;
    logic [23:0] r2_tp;
    logic        r2_ovf;

    logic [15:0] n2_imm16;
    logic [2:0]  n2_scale;
    logic [4:0]  n2_scale_full;
    logic        n2_ovf;
    logic        n2_aligned;

    // true when the bits from lo upward are a sign extension
    function automatic logic sext_ok(input logic [63:0] x, input int lo);
        logic [63:0] hi;
        hi = x >> lo;
        return (hi == '0) || (hi == ({64{1'b1}} >> lo));
    endfunction

    always_comb begin
        n2_scale_full = r1_func - arp_pkg::FN_LO12_S1;
        n2_scale      = n2_scale_full[2:0];
        n2_aligned    = (r1_d[1:0] == 2'b00);
        case (r1_func)
            arp_pkg::FN_MOVW_G0: n2_imm16 = r1_s[15:0];
            arp_pkg::FN_MOVW_G1: n2_imm16 = r1_s[31:16];
            arp_pkg::FN_MOVW_G2: n2_imm16 = r1_s[47:32];
            default:             n2_imm16 = r1_s[63:48];
        endcase
        case (r1_func) inside
            arp_pkg::FN_ADRP, arp_pkg::FN_GOT_PAGE: n2_ovf = !sext_ok(r1_poff, 20);
            arp_pkg::FN_CONDBR19: n2_ovf = !(n2_aligned && sext_ok(r1_d, 20));
            arp_pkg::FN_TSTBR14:  n2_ovf = !(n2_aligned && sext_ok(r1_d, 15));
            arp_pkg::FN_JUMP26, arp_pkg::FN_CALL26:
                                  n2_ovf = !(n2_aligned && sext_ok(r1_d, 27));
            default:              n2_ovf = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_func   <= r1_func;
        r2_insn   <= r1_insn;
        r2_res64  <= r1_res64;
        r2_add32  <= r1_insn + ((r1_func == arp_pkg::FN_PREL32) ? r1_d[31:0] : r1_s[31:0]);
        r2_imm16  <= n2_imm16;
        r2_lo12   <= r1_s[11:0] >> n2_scale;
        r2_page   <= r1_poff[20:0];
        r2_dbr    <= r1_d[27:2];
        r2_got_lo <= r1_got_lo;
        r2_tp     <= r1_tp + {12'd0, r_tcb_bias};
        r2_ovf    <= n2_ovf;
    end

    // ---------------- stage 3: assemble result ----------------
    logic        r3_v;
    arp_pkg::t_reloc_out r3_res;
    arp_pkg::t_reloc_out n3_res;
    logic [31:0] n3_w;
    logic [11:0] n3_tls_imm;

    always_comb begin
        n3_tls_imm = (r2_func == arp_pkg::FN_TLS_HI12) ? r2_tp[23:12] : r2_tp[11:0];
        n3_w       = '0;
        n3_res.new_content = '0;
        n3_res.write_width = arp_pkg::WW_32;
        n3_res.status      = r2_ovf ? arp_pkg::ST_OVERFLOW : arp_pkg::ST_OK;
        case (r2_func) inside
            arp_pkg::FN_ABS64, arp_pkg::FN_GLOB_DAT: begin
                n3_res.write_width = arp_pkg::WW_64;
            end
            arp_pkg::FN_ABS32, arp_pkg::FN_PREL32: begin
                n3_w = r2_add32;
            end
            [arp_pkg::FN_MOVW_G0:arp_pkg::FN_MOVW_G3]: begin
                n3_w = (r2_insn & arp_pkg::MOVW_KEEP) | {11'd0, r2_imm16, 5'd0};
            end
            arp_pkg::FN_ADRP, arp_pkg::FN_GOT_PAGE: begin
                n3_w = (r2_insn & arp_pkg::ADRP_KEEP)
                     | {1'b0, r2_page[1:0], 5'd0, r2_page[20:2], 5'd0};
            end
            [arp_pkg::FN_LO12_S1:arp_pkg::FN_LO12_S16]: begin
                n3_w = (r2_insn & arp_pkg::LO12_KEEP) | {10'd0, r2_lo12, 10'd0};
            end
            arp_pkg::FN_CONDBR19: begin
                n3_w = (r2_insn & arp_pkg::COND_KEEP) | {8'd0, r2_dbr[18:0], 5'd0};
            end
            arp_pkg::FN_TSTBR14: begin
                n3_w = (r2_insn & arp_pkg::TST_KEEP) | {13'd0, r2_dbr[13:0], 5'd0};
            end
            arp_pkg::FN_JUMP26, arp_pkg::FN_CALL26: begin
                n3_w = arp_pkg::B_OPCODE | {6'd0, r2_dbr}
                     | ((r2_func == arp_pkg::FN_CALL26) ? arp_pkg::BL_BIT : 32'd0);
            end
            arp_pkg::FN_GOT_LO12: begin
                n3_w = (r2_insn & arp_pkg::GOTLO_KEEP) | {13'd0, r2_got_lo, 10'd0};
            end
            arp_pkg::FN_TLS_HI12, arp_pkg::FN_TLS_LO12: begin
                n3_w = (r2_insn & arp_pkg::LO12_KEEP) | {10'd0, n3_tls_imm, 10'd0};
            end
            arp_pkg::FN_COPY, arp_pkg::FN_RELATIVE: begin
                n3_res.write_width = arp_pkg::WW_NONE;
            end
            default: begin
                n3_res.write_width = arp_pkg::WW_NONE;
                n3_res.status      = arp_pkg::ST_UNHANDLED;
            end
        endcase
        if (n3_res.write_width == arp_pkg::WW_64) begin
            n3_res.new_content = r2_res64;
        end else if (n3_res.write_width == arp_pkg::WW_32) begin
            n3_res.new_content = {32'd0, n3_w};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_res <= n3_res;
    end

    assign o_done   = r3_v;
    assign o_result = r3_res;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 r2_v ##1 o_done)
        else $error("accepted transfer did not complete after three cycles");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r2_v))
        else $error("result strobe without an item in flight");

    a_unhandled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == arp_pkg::ST_UNHANDLED)
            |-> (o_result.write_width == arp_pkg::WW_NONE && o_result.new_content == '0))
        else $error("unhandled kind produced a write");

    a_word_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.write_width == arp_pkg::WW_32)
            |-> (o_result.new_content[63:32] == 32'd0))
        else $error("32-bit write with nonzero upper half");

endmodule

`default_nettype wire

[verif/reloc_patch_monitor.sv]
`timescale 1ns / 1ps
// Monitor for the relocation patch unit: predicts each patched word and checks the results.
module reloc_patch_monitor (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire                           i_busy,
    input  arp_pkg::t_reloc_in            i_item,
    input  wire                           i_done,
    input  arp_pkg::t_reloc_out           i_result,
    input  wire                           i_cfg_valid,
    input  wire                           i_cfg_ready,
    input  wire [arp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [63:0]                    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam logic [4:0] FN_LO12_S2 = arp_pkg::FN_LO12_S1 + 5'd1;
    localparam logic [4:0] FN_LO12_S4 = arp_pkg::FN_LO12_S1 + 5'd2;
    localparam logic [4:0] FN_LO12_S8 = arp_pkg::FN_LO12_S1 + 5'd3;

    logic [63:0]         tls_base_q;
    logic [11:0]         tcb_bias_q;
    arp_pkg::t_reloc_out patched_q[$];
    arp_pkg::t_reloc_out head;
    int                  mismatches;

    // ADRP-style page delta insert; flags a delta outside signed 21 bits
    function automatic logic [31:0] page_field(input logic [31:0] insn,
                                               input logic [63:0] target,
                                               input logic [63:0] place,
                                               output bit ovf);
        logic [63:0] pages;
        pages = (target >> 12) - (place >> 12);
        ovf = ((pages + 64'h10_0000) >> 21) != 64'd0;
        return (insn & arp_pkg::ADRP_KEEP) | {1'b0, pages[1:0], 5'b0, pages[20:2], 5'b0};
    endfunction

    function automatic arp_pkg::t_reloc_out patch_word(input arp_pkg::t_reloc_in it,
                                                       input logic [63:0] tbase,
                                                       input logic [11:0] bias);
        arp_pkg::t_reloc_out r;
        logic [31:0] insn;
        logic [31:0] w;
        logic [63:0] d;
        logic [63:0] lo;
        logic [63:0] tp;
        logic [11:0] imm;
        int          sc;
        bit          ovf;
        insn = it.old_content[31:0];
        d = it.sym_value - it.place_addr;
        w = '0;
        ovf = 1'b0;
        r.new_content = '0;
        r.write_width = arp_pkg::WW_32;
        r.status = arp_pkg::ST_OK;
        case (it.func)
            arp_pkg::FN_ABS64: begin
                r.new_content = it.old_content + it.sym_value;
                r.write_width = arp_pkg::WW_64;
            end
            arp_pkg::FN_ABS32: w = insn + it.sym_value[31:0];
            arp_pkg::FN_PREL32: w = insn + d[31:0];
            arp_pkg::FN_MOVW_G0, arp_pkg::FN_MOVW_G1, arp_pkg::FN_MOVW_G2,
            arp_pkg::FN_MOVW_G3: begin
                sc = int'(it.func - arp_pkg::FN_MOVW_G0);
                lo = it.sym_value >> (16 * sc);
                w = (insn & arp_pkg::MOVW_KEEP) | {11'b0, lo[15:0], 5'b0};
            end
            arp_pkg::FN_ADRP: w = page_field(insn, it.sym_value, it.place_addr, ovf);
            arp_pkg::FN_LO12_S1, FN_LO12_S2, FN_LO12_S4, FN_LO12_S8,
            arp_pkg::FN_LO12_S16: begin
                // scaled offset: drop the low bits covered by the access size
                sc = int'(it.func - arp_pkg::FN_LO12_S1);
                lo = it.sym_value & 64'hfff & ~((64'd1 << sc) - 64'd1);
                lo = lo << (10 - sc);
                w = (insn & arp_pkg::LO12_KEEP) | lo[31:0];
            end
            arp_pkg::FN_CONDBR19: begin
                ovf = ((d + 64'h10_0000) & ~64'h1f_fffc) != 64'd0;
                w = (insn & arp_pkg::COND_KEEP) | {8'b0, d[20:2], 5'b0};
            end
            arp_pkg::FN_TSTBR14: begin
                ovf = ((d + 64'h8000) & ~64'hfffc) != 64'd0;
                w = (insn & arp_pkg::TST_KEEP) | {13'b0, d[15:2], 5'b0};
            end
            arp_pkg::FN_JUMP26, arp_pkg::FN_CALL26: begin
                ovf = ((d + 64'h800_0000) & ~64'hfff_fffc) != 64'd0;
                w = arp_pkg::B_OPCODE | {6'b0, d[27:2]};
                if (it.func == arp_pkg::FN_CALL26) w = w | arp_pkg::BL_BIT;
            end
            arp_pkg::FN_GOT_PAGE:
                w = page_field(insn, it.got_entry_addr, it.place_addr, ovf);
            arp_pkg::FN_GOT_LO12:
                w = (insn & arp_pkg::GOTLO_KEEP) | {13'b0, it.got_entry_addr[11:3], 10'b0};
            arp_pkg::FN_GLOB_DAT: begin
                r.new_content = it.sym_value - it.addend;
                r.write_width = arp_pkg::WW_64;
            end
            arp_pkg::FN_TLS_HI12, arp_pkg::FN_TLS_LO12: begin
                tp = it.sym_value - tbase + {52'b0, bias};
                imm = (it.func == arp_pkg::FN_TLS_HI12) ? tp[23:12] : tp[11:0];
                w = (insn & arp_pkg::LO12_KEEP) | {10'b0, imm, 10'b0};
            end
            arp_pkg::FN_COPY, arp_pkg::FN_RELATIVE: r.write_width = arp_pkg::WW_NONE;
            default: begin
                r.write_width = arp_pkg::WW_NONE;
                r.status = arp_pkg::ST_UNHANDLED;
            end
        endcase
        if (r.write_width == arp_pkg::WW_32) r.new_content = {32'b0, w};
        if (ovf) r.status = arp_pkg::ST_OVERFLOW;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tls_base_q = '0;
            tcb_bias_q = arp_pkg::TCB_BIAS_RESET;
            patched_q.delete();
            mismatches = 0;
        end else begin
            if (i_done) begin
                if (patched_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none expected: %h/%0d/%0d",
                                 $realtime, i_result.new_content, i_result.write_width,
                                 i_result.status);
                end else begin
                    head = patched_q.pop_front();
                    if (i_result.new_content !== head.new_content ||
                        i_result.write_width !== head.write_width ||
                        i_result.status !== head.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                                     $realtime, head.new_content, head.write_width, head.status,
                                     i_result.new_content, i_result.write_width,
                                     i_result.status);
                    end
                end
            end
            // items accepted on this edge still see the old register values
            if (i_start && !i_busy)
                patched_q.push_back(patch_word(i_item, tls_base_q, tcb_bias_q));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == arp_pkg::CFG_TLS_BASE) tls_base_q = i_cfg_data;
                else if (i_cfg_index == arp_pkg::CFG_TCB_BIAS) tcb_bias_q = i_cfg_data[11:0];
            end
        end
        o_fail_count <= mismatches;
        o_pending <= patched_q.size();
    end

endmodule

[verif/aarch64_reloc_patch_test.sv]
`timescale 1ns / 1ps
// Testbench top for the relocation patch unit: clock, reset, stimulus, register writes, verdict.
module aarch64_reloc_patch_test;

    localparam int N_BLOCKS = 6;
    localparam int BLOCK_ITEMS = 300;
    localparam logic [4:0] FN_LAST = 5'd31;
    localparam logic [arp_pkg::CFG_IDX_W-1:0] CFG_NO_REG = arp_pkg::CFG_TCB_BIAS + 8'd1;
    localparam logic [arp_pkg::CFG_IDX_W-1:0] CFG_TOP_IDX = '1;
    localparam logic [63:0] P0 = 64'h0000_7fff_1234_5678;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    arp_pkg::t_reloc_in            item;
    logic                          done;
    arp_pkg::t_reloc_out           result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [arp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0]                   cfg_data;
    int                            fail_count;
    int                            pending;

    int                 idle_pct;
    int                 burst_left;
    logic [63:0]        tls_now;
    arp_pkg::t_reloc_in directed_q[$];

    always #2 clk = ~clk;

    aarch64_reloc_patch dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (item),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    reloc_patch_monitor u_mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // signed distance: mostly short aligned hops, some right at a field's range limit
    function automatic logic [63:0] rand_offset();
        logic [63:0] r;
        int          k;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: k = 15;
                1: k = 20;
                2: k = 27;
                default: k = 32;
            endcase
            r = 64'd1 << k;
            if ($urandom_range(0, 1)) r = r - 64'd4;
            if ($urandom_range(0, 1)) r = -r;
        end else begin
            k = $urandom_range(0, 34);
            r = rand64() & ((64'd1 << k) - 64'd1);
            if ($urandom_range(0, 1)) r = -r;
            if ($urandom_range(0, 4) != 0) r[1:0] = 2'b00;
        end
        return r;
    endfunction

    function automatic arp_pkg::t_reloc_in reloc(input logic [4:0] fn,
                                                 input logic [63:0] old,
                                                 input logic [63:0] p, input logic [63:0] s,
                                                 input logic [63:0] a, input logic [63:0] got);
        arp_pkg::t_reloc_in r;
        r.func = fn;
        r.old_content = old;
        r.place_addr = p;
        r.sym_value = s;
        r.addend = a;
        r.got_entry_addr = got;
        return r;
    endfunction

    function automatic arp_pkg::t_reloc_in rand_reloc(input logic [63:0] tbase);
        arp_pkg::t_reloc_in r;
        if ($urandom_range(0, 19) == 0)
            r.func = 5'($urandom_range(arp_pkg::FN_RELATIVE + 5'd1, FN_LAST));
        else
            r.func = 5'($urandom_range(arp_pkg::FN_ABS64, arp_pkg::FN_RELATIVE));
        r.old_content = rand64();
        r.place_addr = rand64();
        if ($urandom_range(0, 9) < 7) begin
            if (r.func == arp_pkg::FN_TLS_HI12 || r.func == arp_pkg::FN_TLS_LO12)
                r.sym_value = tbase + rand_offset();
            else
                r.sym_value = r.place_addr + rand_offset();
            r.got_entry_addr = r.place_addr + rand_offset();
        end else begin
            r.sym_value = rand64();
            r.got_entry_addr = rand64();
        end
        r.addend = $urandom_range(0, 1) ? rand64() : rand_offset();
        return r;
    endfunction

    // start stays high into the next transfer unless the sender idles
    task automatic push_reloc(input arp_pkg::t_reloc_in it);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
            while ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                item <= rand_reloc(tls_now);
                @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [arp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial begin
        #1_600_000;
        $display("aarch64_reloc_patch_test: FAIL");
        $finish;
    end

    initial begin
        start <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        tls_now = '0;
        idle_pct = 7;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at reset register values
        directed_q.push_back(reloc(arp_pkg::FN_ABS64, '1, P0, 64'd1, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_ABS32, {32'hdead_beef, 32'hffff_ffff}, P0,
                                   64'h1_0000_0001, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_PREL32, '0, '1, '0, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_MOVW_G0, '1, P0, 64'hfedc_ba98_7654_3210,
                                   '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_MOVW_G1, '1, P0, 64'hfedc_ba98_7654_3210,
                                   '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_MOVW_G2, '1, P0, 64'hfedc_ba98_7654_3210,
                                   '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_MOVW_G3, '1, P0, 64'hfedc_ba98_7654_3210,
                                   '0, '0));
        // page delta one past the positive limit
        directed_q.push_back(reloc(arp_pkg::FN_ADRP, '1, '0, 64'h1_0000_0000, '0, '0));
        for (int k = 0; k < 5; k++)
            directed_q.push_back(reloc(arp_pkg::FN_LO12_S1 + 5'(k), '0, P0, '1, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_CONDBR19, '1, P0, P0 - 64'h10_0000, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_TSTBR14, '1, P0, P0 + 64'h8000, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_JUMP26, '0, P0, P0 + 64'h7ff_fffc, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_CALL26, '1, P0, P0 - 64'h800_0004, '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_GOT_PAGE, '1, P0, '0, '0,
                                   P0 - 64'h1_0000_0000));
        directed_q.push_back(reloc(arp_pkg::FN_GOT_LO12, 64'h5555_5555_5555_5555, P0, '0, '0,
                                   64'haaaa_aaaa_aaaa_aaaa));
        directed_q.push_back(reloc(arp_pkg::FN_COPY, '1, '1, '1, '1, '1));
        directed_q.push_back(reloc(arp_pkg::FN_GLOB_DAT, '1, P0, '0, 64'd1, '0));
        directed_q.push_back(reloc(arp_pkg::FN_TLS_HI12, '1, P0, 64'hffff_ffff_ffff_fff0,
                                   '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_TLS_LO12, '0, P0, 64'h0000_0000_00ff_ffef,
                                   '0, '0));
        directed_q.push_back(reloc(arp_pkg::FN_RELATIVE, '1, P0, '1, '1, '1));
        directed_q.push_back(reloc(FN_LAST, '1, '1, '1, '1, '1));
        foreach (directed_q[i]) begin
            push_reloc(directed_q[i]);
            pace_sender();
        end

        for (int b = 0; b < N_BLOCKS; b++) begin
            drain();
            case (b)
                0: begin
                    tls_now = '0;
                    write_reg(arp_pkg::CFG_TLS_BASE, tls_now);
                    write_reg(arp_pkg::CFG_TCB_BIAS, 64'd16);
                    write_reg(CFG_NO_REG, rand64());
                end
                1: begin
                    tls_now = '1;
                    write_reg(arp_pkg::CFG_TLS_BASE, tls_now);
                    write_reg(arp_pkg::CFG_TCB_BIAS, '1);
                end
                2: begin
                    tls_now = rand64();
                    write_reg(arp_pkg::CFG_TLS_BASE, tls_now);
                    // only bits above the register width set
                    write_reg(arp_pkg::CFG_TCB_BIAS, rand64() << 12);
                end
                3: begin
                    tls_now = '0;
                    write_reg(arp_pkg::CFG_TLS_BASE, tls_now);
                    write_reg(arp_pkg::CFG_TCB_BIAS, rand64());
                    write_reg(CFG_TOP_IDX, rand64());
                end
                4: begin
                    tls_now = rand64();
                    write_reg(arp_pkg::CFG_TLS_BASE, tls_now);
                    write_reg(arp_pkg::CFG_TCB_BIAS, rand64());
                end
                default: begin
                    tls_now = 64'h8000_0000_0000_0000;
                    write_reg(arp_pkg::CFG_TLS_BASE, tls_now);
                    write_reg(arp_pkg::CFG_TCB_BIAS, 64'd1);
                end
            endcase
            cfg_valid <= 1'b0;
            idle_pct = (b < 2) ? 7 : (b < 4) ? 82 : 0;
            burst_left = 0;
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
                push_reloc(rand_reloc(tls_now));
                pace_sender();
            end
        end

        drain();
        if (fail_count == 0)
            $display("aarch64_reloc_patch_test: PASS");
        else
            $display("aarch64_reloc_patch_test: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/arp_pkg.sv
rtl/core/aarch64_reloc_patch.sv
verif/reloc_patch_monitor.sv
verif/aarch64_reloc_patch_test.sv
